FILE: sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge while reset is released.
`define MMAE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Checks a property on every rising edge, reset included.
`define MMAE_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/mmae_pkg.sv
package mmae_pkg;

    localparam int DATA_W    = 32;
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int OUT_POS_W = 3;

    localparam logic             MODE_ADD    = 1'b0;
    localparam logic             MODE_MUL    = 1'b1;
    localparam logic             OP_MODE_RST = MODE_MUL;
    localparam logic [CFG_W-1:0] DIM_RST     = 4'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OP_MODE = 2'd0,
        CFG_A_ROWS  = 2'd1,
        CFG_A_COLS  = 2'd2,
        CFG_B_COLS  = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_LOAD  = 2'd0,
        ST_MAC   = 2'd1,
        ST_DRAIN = 2'd2
    } t_state;

endpackage

FILE: sv/mmae_ram.sv
module mmae_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/matrix_multiply_add_engine_top.sv
// Loads matrix A and then matrix B, one signed element per request in row-major order, into
// two single-port-write memories at one element per cycle, and then streams out the result
// matrix in row-major order with the row and column of each element and a flag on the final
// one. Dimensions and the operation come from the configuration registers, which the user must
// write only while the block is idle; the block itself does not enforce this. Any write
// restarts loading with the first element of A. While the result is computed the input is
// stalled. In multiply mode one shared multiply-accumulate unit reads one element pair per
// cycle; each result element passes through the memory read register, the product register
// and the accumulator before it is handed over to the output register. In add mode each
// result element is the sum of one element pair.
`include "assert_macros.svh"

module matrix_multiply_add_engine_top
    import mmae_pkg::*;
#(
    parameter int MAX_DIM = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [DATA_W-1:0]    i_element,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [DATA_W-1:0]    o_product_value,
    output logic [OUT_POS_W-1:0] o_out_row,
    output logic [OUT_POS_W-1:0] o_out_col,
    output logic                 o_last
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int POS_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] d);
        logic [DIM_W-1:0] res;
        if (d == '0) begin
            res = DIM_W'(1);
        end else if (int'(d) > MAX_DIM) begin
            res = DIM_W'(MAX_DIM);
        end else begin
            res = DIM_W'(d);
        end
        return res;
    endfunction

    logic             r_op_mode;
    logic [CFG_W-1:0] r_a_rows;
    logic [CFG_W-1:0] r_a_cols;
    logic [CFG_W-1:0] r_b_cols;

    t_state r_state;
    t_state n_state;

    logic [CNT_W-1:0]  r_cnt;
    logic              r_phase_b;
    logic [POS_W-1:0]  r_row;
    logic [POS_W-1:0]  r_col;
    logic [POS_W-1:0]  r_k;
    logic [ADDR_W-1:0] r_a_base;
    logic [ADDR_W-1:0] r_a_ptr;
    logic [ADDR_W-1:0] r_b_ptr;

    logic              r_p1_vld;
    logic              r_p1_first;
    logic              r_p2_vld;
    logic              r_p2_first;
    logic [DATA_W-1:0] r_prod;
    logic [DATA_W-1:0] r_acc;

    logic              r_o_valid;
    logic [DATA_W-1:0] r_o_value;
    logic [POS_W-1:0]  r_o_row;
    logic [POS_W-1:0]  r_o_col;
    logic              r_o_last;

    logic [DIM_W-1:0]  nr;
    logic [DIM_W-1:0]  nk;
    logic [DIM_W-1:0]  nc;
    logic [DIM_W-1:0]  klen;
    logic [CNT_W-1:0]  na;
    logic [CNT_W-1:0]  nb;
    logic              in_acc;
    logic              we_a;
    logic              we_b;
    logic              cnt_end;
    logic              load_done;
    logic              k_last;
    logic              col_last;
    logic              row_last;
    logic              final_elem;
    logic              rd_en;
    logic              out_load;
    logic [ADDR_W-1:0] n_next_base;
    logic [ADDR_W-1:0] n_next_lin;
    logic [DATA_W-1:0] a_rd;
    logic [DATA_W-1:0] b_rd;

    assign nr   = clamp_dim(r_a_rows);
    assign nk   = clamp_dim(r_a_cols);
    assign nc   = (r_op_mode == MODE_MUL) ? clamp_dim(r_b_cols) : nk;
    assign klen = (r_op_mode == MODE_MUL) ? nk : DIM_W'(1);
    assign na   = CNT_W'(nr) * CNT_W'(nk);
    assign nb   = (r_op_mode == MODE_MUL) ? CNT_W'(nk) * CNT_W'(nc) : na;

    assign in_acc    = i_valid && !o_stall;
    assign we_a      = in_acc && !r_phase_b;
    assign we_b      = in_acc && r_phase_b;
    assign cnt_end   = r_phase_b ? (r_cnt + CNT_W'(1) == nb) : (r_cnt + CNT_W'(1) == na);
    assign load_done = in_acc && r_phase_b && cnt_end;

    assign k_last     = (DIM_W'(r_k) + DIM_W'(1) == klen);
    assign col_last   = (DIM_W'(r_col) + DIM_W'(1) == nc);
    assign row_last   = (DIM_W'(r_row) + DIM_W'(1) == nr);
    assign final_elem = row_last && col_last;

    assign n_next_base = r_a_base + ADDR_W'(nk);
    assign n_next_lin  = r_a_base + ADDR_W'(r_col) + ADDR_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op_mode <= OP_MODE_RST;
            r_a_rows  <= DIM_RST;
            r_a_cols  <= DIM_RST;
            r_b_cols  <= DIM_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_OP_MODE: begin
                    r_op_mode <= i_cfg_data[0];
                end
                CFG_A_ROWS: begin
                    r_a_rows <= i_cfg_data;
                end
                CFG_A_COLS: begin
                    r_a_cols <= i_cfg_data;
                end
                CFG_B_COLS: begin
                    r_b_cols <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_phase_b <= 1'b0;
        end else if (i_cfg_we) begin
            r_cnt     <= '0;
            r_phase_b <= 1'b0;
        end else if (in_acc) begin
            if (cnt_end) begin
                r_cnt     <= '0;
                r_phase_b <= !r_phase_b;
            end else begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (load_done) begin
                    n_state = ST_MAC;
                end
            end
            ST_MAC: begin
                if (k_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (out_load) begin
                    n_state = final_elem ? ST_LOAD : ST_MAC;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_comb begin
        o_stall  = (r_state != ST_LOAD);
        rd_en    = (r_state == ST_MAC);
        out_load = (r_state == ST_DRAIN) && !r_p1_vld && !r_p2_vld &&
                   (!r_o_valid || !i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row    <= '0;
            r_col    <= '0;
            r_k      <= '0;
            r_a_base <= '0;
            r_a_ptr  <= '0;
            r_b_ptr  <= '0;
        end else if (load_done) begin
            r_row    <= '0;
            r_col    <= '0;
            r_k      <= '0;
            r_a_base <= '0;
            r_a_ptr  <= '0;
            r_b_ptr  <= '0;
        end else if (rd_en && !k_last) begin
            r_k     <= r_k + POS_W'(1);
            r_a_ptr <= r_a_ptr + ADDR_W'(1);
            r_b_ptr <= r_b_ptr + ADDR_W'(nc);
        end else if (out_load && !final_elem) begin
            r_k <= '0;
            if (col_last) begin
                r_col    <= '0;
                r_row    <= r_row + POS_W'(1);
                r_a_base <= n_next_base;
                r_a_ptr  <= n_next_base;
                r_b_ptr  <= (r_op_mode == MODE_MUL) ? '0 : n_next_base;
            end else begin
                r_col   <= r_col + POS_W'(1);
                r_a_ptr <= (r_op_mode == MODE_MUL) ? r_a_base : n_next_lin;
                r_b_ptr <= (r_op_mode == MODE_MUL) ? ADDR_W'(r_col) + ADDR_W'(1) : n_next_lin;
            end
        end
    end

    mmae_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_a_ram (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (r_cnt[ADDR_W-1:0]),
        .i_wdata (i_element),
        .i_raddr (r_a_ptr),
        .o_rdata (a_rd)
    );

    mmae_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_b_ram (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (r_cnt[ADDR_W-1:0]),
        .i_wdata (i_element),
        .i_raddr (r_b_ptr),
        .o_rdata (b_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
        end else begin
            r_p1_vld <= rd_en;
            r_p2_vld <= r_p1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_first <= (r_k == '0);
        r_p2_first <= r_p1_first;
        r_prod     <= (r_op_mode == MODE_MUL) ? DATA_W'(a_rd * b_rd) : a_rd + b_rd;
        if (r_p2_vld) begin
            r_acc <= r_p2_first ? r_prod : r_acc + r_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_load) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_value <= r_acc;
            r_o_row   <= r_row;
            r_o_col   <= r_col;
            r_o_last  <= final_elem;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_product_value = r_o_value;
    assign o_out_row       = OUT_POS_W'(r_o_row);
    assign o_out_col       = OUT_POS_W'(r_o_col);
    assign o_last          = r_o_last;

    `MMAE_ASSERT(a_wr_in_load, i_clk, i_rst_n, (we_a || we_b) |-> (r_state == ST_LOAD), "Store written outside loading.")
    `MMAE_ASSERT(a_k_in_range, i_clk, i_rst_n, (r_state == ST_MAC) |-> (DIM_W'(r_k) < klen), "Inner index beyond its length.")
    `MMAE_ASSERT(a_flight_busy, i_clk, i_rst_n, (r_p1_vld || r_p2_vld) |-> (r_state != ST_LOAD), "Reads in flight while loading.")
    `MMAE_ASSERT(a_drain_entry, i_clk, i_rst_n, (r_state == ST_DRAIN && $past(r_state) == ST_MAC) |-> r_p1_vld, "Drain entered without a final read.")
    `MMAE_ASSERT_NR(a_reset_idle, i_clk, !i_rst_n |=> (r_state == ST_LOAD && !r_o_valid), "Block not idle after reset.")

endmodule
